// ----- hw/rtl/bpwf_pkg.sv -----
// ----------------------------------------------------------------------------
// bpwf_pkg
// Shared types, widths and constants of the beam pair wall follow velocity
// block: beam direction coefficients, the queue entry and the iteration sizes.
// ----------------------------------------------------------------------------
package bpwf_pkg;

    localparam int NUM_BEAMS   = 9;
    localparam int BEAM_W      = 16;
    localparam int BIDX_W      = 4;
    localparam int POS_W       = 24;
    localparam int PAIR_W      = 4;
    localparam int VEL_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd1;

    localparam logic [CFG_W-1:0] SAFE_RESET  = 16'd512;
    localparam logic [CFG_W-1:0] SPEED_RESET = 16'd768;

    // Q16 value of cos(30 degrees) as 0.866.
    localparam logic [15:0] Q_COS30 = 16'd56754;

    // Square root and divider sizing.
    localparam int SQ_IN_W   = 56;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int REM_W     = ROOT_W + 4;
    localparam int SQ_STEPS  = 4;
    localparam int SQ_CYC    = ROOT_W / SQ_STEPS;
    localparam int Q_W       = 16;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYC   = Q_W / DIV_STEPS;
    localparam int NUM_W     = 44;
    localparam int CNT_W     = $clog2(SQ_CYC);

    typedef enum logic [1:0] {
        M_ZERO,
        M_HALF,
        M_COS30,
        M_ONE
    } t_mag;

    typedef struct packed {
        logic neg;
        t_mag mag;
    } t_coef;

    // One classified item as it waits for the velocity unit.
    typedef struct packed {
        logic [PAIR_W-1:0]       pair;
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
    } t_wall;

    // Direction cosine of each beam, +120 down to -120 degrees.
    function automatic t_coef cos_sel(input logic [BIDX_W-1:0] idx);
        t_coef c;
        unique case (idx)
            4'd0:    c = '{neg: 1'b1, mag: M_HALF};
            4'd1:    c = '{neg: 1'b0, mag: M_ZERO};
            4'd2:    c = '{neg: 1'b0, mag: M_HALF};
            4'd3:    c = '{neg: 1'b0, mag: M_COS30};
            4'd4:    c = '{neg: 1'b0, mag: M_ONE};
            4'd5:    c = '{neg: 1'b0, mag: M_COS30};
            4'd6:    c = '{neg: 1'b0, mag: M_HALF};
            4'd7:    c = '{neg: 1'b0, mag: M_ZERO};
            4'd8:    c = '{neg: 1'b1, mag: M_HALF};
            default: c = '{neg: 1'b0, mag: M_ZERO};
        endcase
        return c;
    endfunction

    // Direction sine of each beam, +120 down to -120 degrees.
    function automatic t_coef sin_sel(input logic [BIDX_W-1:0] idx);
        t_coef c;
        unique case (idx)
            4'd0:    c = '{neg: 1'b0, mag: M_COS30};
            4'd1:    c = '{neg: 1'b0, mag: M_ONE};
            4'd2:    c = '{neg: 1'b0, mag: M_COS30};
            4'd3:    c = '{neg: 1'b0, mag: M_HALF};
            4'd4:    c = '{neg: 1'b0, mag: M_ZERO};
            4'd5:    c = '{neg: 1'b1, mag: M_HALF};
            4'd6:    c = '{neg: 1'b1, mag: M_COS30};
            4'd7:    c = '{neg: 1'b1, mag: M_ONE};
            4'd8:    c = '{neg: 1'b1, mag: M_COS30};
            default: c = '{neg: 1'b0, mag: M_ZERO};
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/beam_pair_wall_follow_velocity.sv -----
// ----------------------------------------------------------------------------
// beam_pair_wall_follow_velocity
// Wall-following avoidance velocity from a nine-beam range scan.
// ----------------------------------------------------------------------------
// A scan is taken when i_start is high and o_busy is low. The front classifies
// it through its stage register and places it in a four-entry queue, so up to
// five scans can be taken back to back. The velocity unit then takes a scan
// from the queue in its idle state and steps through the deltas, the
// multiplies, the square root at four root bits per cycle, the divide setup
// and the divide at four quotient bits per cycle; it takes no new scan from
// the queue until the current one is done. A scan with no obstacle or a
// zero-length wall line skips the divide. Each result appears for a single
// cycle with o_valid high and must be captured then. Configuration writes
// take effect at once; the user is to make them only while no scan is in
// flight, and the block itself does not enforce this.
module beam_pair_wall_follow_velocity #(
    parameter int QUEUE_DEPTH = bpwf_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_cfg_we,
    input  logic [bpwf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpwf_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_1,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_2,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_3,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_4,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_5,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_6,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_7,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_8,
    input  logic [bpwf_pkg::BEAM_W-1:0]         i_beam_9,
    input  logic signed [bpwf_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [bpwf_pkg::POS_W-1:0]   i_pos_y,
    output logic                                o_valid,
    output logic [bpwf_pkg::PAIR_W-1:0]         o_pair_index,
    output logic signed [bpwf_pkg::VEL_W-1:0]   o_vel_x,
    output logic signed [bpwf_pkg::VEL_W-1:0]   o_vel_y,
    output logic signed [bpwf_pkg::POS_W-1:0]   o_wall_x1,
    output logic signed [bpwf_pkg::POS_W-1:0]   o_wall_y1,
    output logic signed [bpwf_pkg::POS_W-1:0]   o_wall_x2,
    output logic signed [bpwf_pkg::POS_W-1:0]   o_wall_y2
);

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [bpwf_pkg::CFG_W-1:0]   r_safe;
    logic [bpwf_pkg::CFG_W-1:0]   r_speed;
    logic [bpwf_pkg::NUM_BEAMS-1:0][bpwf_pkg::BEAM_W-1:0] w_beams;
    logic                         w_load;
    logic                         w_front_busy;
    logic                         w_push;
    bpwf_pkg::t_wall              w_entry;
    bpwf_pkg::t_wall              w_head;
    logic                         w_empty;
    logic                         w_pop;
    logic [QCNT_W-1:0]            w_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe  <= bpwf_pkg::SAFE_RESET;
            r_speed <= bpwf_pkg::SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpwf_pkg::CFG_SAFE:  r_safe  <= i_cfg_data;
                bpwf_pkg::CFG_SPEED: r_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Busy once every queue slot is taken or reserved by the front stage.
    assign o_busy = ({1'b0, w_count} + (QCNT_W + 1)'(w_front_busy))
                    >= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign w_load = i_start && !o_busy;

    assign w_beams = {i_beam_9, i_beam_8, i_beam_7, i_beam_6, i_beam_5,
                      i_beam_4, i_beam_3, i_beam_2, i_beam_1};

    bpwf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_safe  (r_safe),
        .i_beams (w_beams),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .o_busy  (w_front_busy),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    bpwf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    bpwf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_speed      (r_speed),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_pair_index (o_pair_index),
        .o_vel_x      (o_vel_x),
        .o_vel_y      (o_vel_y),
        .o_wall_x1    (o_wall_x1),
        .o_wall_y1    (o_wall_y1),
        .o_wall_x2    (o_wall_x2),
        .o_wall_y2    (o_wall_y2)
    );

    // The x velocity comes from the absolute x delta of the wall line, so it is never negative.
    a_velx_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_vel_x[bpwf_pkg::VEL_W-1])
        else $error("negative x velocity");

    // No obstacle leaves velocity and wall points at zero.
    a_no_obstacle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pair_index == '0) |->
        (o_vel_x == '0 && o_vel_y == '0 && o_wall_x1 == '0 && o_wall_y1 == '0
         && o_wall_x2 == '0 && o_wall_y2 == '0))
        else $error("nonzero result without obstacle");

    // An accepted scan is pushed into the queue from the front's stage register.
    a_load_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> w_push)
        else $error("accepted scan not forwarded");

    // The queue never overflows.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_count != QCNT_W'(QUEUE_DEPTH) || w_pop))
        else $error("queue overflow");

endmodule

// ----- hw/rtl/bpwf_front.sv -----
// ----------------------------------------------------------------------------
// bpwf_front
// Classifies a scan: finds the first adjacent beam pair under the threshold,
// scales the two ranges into offsets and places the saturated hit points.
// ----------------------------------------------------------------------------
module bpwf_front (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_load,
    input  logic [bpwf_pkg::CFG_W-1:0]                      i_safe,
    input  logic [bpwf_pkg::NUM_BEAMS-1:0][bpwf_pkg::BEAM_W-1:0] i_beams,
    input  logic signed [bpwf_pkg::POS_W-1:0]               i_pos_x,
    input  logic signed [bpwf_pkg::POS_W-1:0]               i_pos_y,
    output logic                                            o_busy,
    output logic                                            o_push,
    output bpwf_pkg::t_wall                                 o_entry
);

    logic [bpwf_pkg::NUM_BEAMS-1:0]  w_lt;
    logic [bpwf_pkg::PAIR_W-1:0]     w_pair;
    logic [bpwf_pkg::BIDX_W-1:0]     w_k;
    logic [bpwf_pkg::BEAM_W-1:0]     w_ba;
    logic [bpwf_pkg::BEAM_W-1:0]     w_bb;

    logic                            r_vld;
    logic [bpwf_pkg::PAIR_W-1:0]     r_pair;
    logic [bpwf_pkg::BIDX_W-1:0]     r_k;
    logic [bpwf_pkg::BEAM_W-1:0]     r_ba;
    logic [bpwf_pkg::BEAM_W-1:0]     r_bb;
    logic [31:0]                     r_pa;
    logic [31:0]                     r_pb;
    logic signed [bpwf_pkg::POS_W-1:0] r_px;
    logic signed [bpwf_pkg::POS_W-1:0] r_py;

    // Threshold compare and first-pair priority pick.
    always_comb begin
        for (int k = 0; k < bpwf_pkg::NUM_BEAMS; k++) begin
            w_lt[k] = i_beams[k] < i_safe;
        end
        w_pair = '0;
        for (int k = bpwf_pkg::NUM_BEAMS - 2; k >= 0; k--) begin
            if (w_lt[k] && w_lt[k+1]) begin
                w_pair = bpwf_pkg::PAIR_W'(k + 1);
            end
        end
        w_k  = (w_pair == '0) ? '0 : bpwf_pkg::BIDX_W'(w_pair - 1'b1);
        w_ba = i_beams[w_k];
        w_bb = i_beams[w_k + 1'b1];
    end

    // Stage register: selected ranges and their cos(30) products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_load;
        end
        if (i_load) begin
            r_pair <= w_pair;
            r_k    <= w_k;
            r_ba   <= w_ba;
            r_bb   <= w_bb;
            r_pa   <= w_ba * bpwf_pkg::Q_COS30;
            r_pb   <= w_bb * bpwf_pkg::Q_COS30;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
        end
    end

    // Rounded signed offset of one range along one coefficient.
    function automatic logic signed [17:0] offset(
        input logic [bpwf_pkg::BEAM_W-1:0] beam,
        input logic [31:0]                 prod,
        input bpwf_pkg::t_coef             c
    );
        logic [16:0] mag;
        logic [32:0] rnd;
        rnd = {1'b0, prod} + 33'd32768;
        case (c.mag)
            bpwf_pkg::M_ZERO:  mag = '0;
            bpwf_pkg::M_HALF:  mag = 17'(({1'b0, beam} + 17'd1) >> 1);
            bpwf_pkg::M_COS30: mag = rnd[32:16];
            bpwf_pkg::M_ONE:   mag = {1'b0, beam};
            default:           mag = '0;
        endcase
        return c.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // Position plus offset, saturated to the position range.
    function automatic logic signed [bpwf_pkg::POS_W-1:0] place(
        input logic signed [bpwf_pkg::POS_W-1:0] pos,
        input logic signed [17:0]                off
    );
        logic signed [25:0] sum;
        sum = {{2{pos[23]}}, pos} + {{8{off[17]}}, off};
        if (sum[25:23] == 3'b000 || sum[25:23] == 3'b111) begin
            return sum[23:0];
        end
        return sum[25] ? 24'sh800000 : 24'sh7FFFFF;
    endfunction

    // Hit points go straight into the queue; no obstacle gives zeros.
    always_comb begin
        o_push        = r_vld;
        o_busy        = r_vld;
        o_entry.pair  = r_pair;
        if (r_pair == '0) begin
            o_entry.x1 = '0;
            o_entry.y1 = '0;
            o_entry.x2 = '0;
            o_entry.y2 = '0;
        end else begin
            o_entry.x1 = place(r_px, offset(r_ba, r_pa, bpwf_pkg::cos_sel(r_k)));
            o_entry.y1 = place(r_py, offset(r_ba, r_pa, bpwf_pkg::sin_sel(r_k)));
            o_entry.x2 = place(r_px, offset(r_bb, r_pb, bpwf_pkg::cos_sel(r_k + 1'b1)));
            o_entry.y2 = place(r_py, offset(r_bb, r_pb, bpwf_pkg::sin_sel(r_k + 1'b1)));
        end
    end

endmodule

// ----- hw/rtl/bpwf_queue.sv -----
// ----------------------------------------------------------------------------
// bpwf_queue
// Short FIFO of classified items between the front and the velocity unit.
// ----------------------------------------------------------------------------
module bpwf_queue #(
    parameter int DEPTH = bpwf_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bpwf_pkg::t_wall              i_data,
    input  logic                         i_pop,
    output bpwf_pkg::t_wall              o_head,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);

    bpwf_pkg::t_wall             r_mem [DEPTH];
    logic [PTR_W-1:0]            r_wr;
    logic [PTR_W-1:0]            r_rd;
    logic [$clog2(DEPTH+1)-1:0]  r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- hw/rtl/bpwf_back.sv -----
// ----------------------------------------------------------------------------
// bpwf_back
// Velocity unit: wall line length by an iterative square root, then the two
// velocity components by a shared-schedule restoring divide, with rounding
// and saturation.
// ----------------------------------------------------------------------------
module bpwf_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bpwf_pkg::CFG_W-1:0]         i_speed,
    input  bpwf_pkg::t_wall                    i_head,
    input  logic                               i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    output logic [bpwf_pkg::PAIR_W-1:0]        o_pair_index,
    output logic signed [bpwf_pkg::VEL_W-1:0]  o_vel_x,
    output logic signed [bpwf_pkg::VEL_W-1:0]  o_vel_y,
    output logic signed [bpwf_pkg::POS_W-1:0]  o_wall_x1,
    output logic signed [bpwf_pkg::POS_W-1:0]  o_wall_y1,
    output logic signed [bpwf_pkg::POS_W-1:0]  o_wall_x2,
    output logic signed [bpwf_pkg::POS_W-1:0]  o_wall_y2
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL1,
        S_MUL2,
        S_SQRT,
        S_DSET,
        S_DIV
    } t_state;

    t_state                              r_state;
    bpwf_pkg::t_wall                     r_ent;
    logic                                r_xneg;
    logic                                r_yneg;
    logic                                r_zero;
    logic [bpwf_pkg::POS_W-1:0]          r_ax;
    logic [bpwf_pkg::POS_W-1:0]          r_ay;
    logic [2*bpwf_pkg::POS_W-1:0]        r_sqx;
    logic [2*bpwf_pkg::POS_W-1:0]        r_sqy;
    logic [bpwf_pkg::SQ_IN_W-1:0]        r_s;
    logic [bpwf_pkg::ROOT_W-1:0]         r_root;
    logic [bpwf_pkg::REM_W-1:0]          r_rem;
    logic [bpwf_pkg::NUM_W-1:0]          r_nx;
    logic [bpwf_pkg::NUM_W-1:0]          r_ny;
    logic [bpwf_pkg::NUM_W-1:0]          r_div;
    logic [bpwf_pkg::Q_W-1:0]            r_qx;
    logic [bpwf_pkg::Q_W-1:0]            r_qy;
    logic [bpwf_pkg::CNT_W-1:0]          r_cnt;

    logic signed [bpwf_pkg::POS_W:0]     w_dx;
    logic signed [bpwf_pkg::POS_W:0]     w_dy;
    logic [bpwf_pkg::CFG_W+bpwf_pkg::POS_W-1:0] w_mx;
    logic [bpwf_pkg::CFG_W+bpwf_pkg::POS_W-1:0] w_my;
    logic [bpwf_pkg::SQ_IN_W-1:0]        n_s;
    logic [bpwf_pkg::ROOT_W-1:0]         n_root;
    logic [bpwf_pkg::REM_W-1:0]          n_rem;
    logic [bpwf_pkg::REM_W-1:0]          w_trial;
    logic [bpwf_pkg::NUM_W-1:0]          n_nx;
    logic [bpwf_pkg::NUM_W-1:0]          n_ny;
    logic [bpwf_pkg::NUM_W-1:0]          n_div;
    logic [bpwf_pkg::Q_W-1:0]            n_qx;
    logic [bpwf_pkg::Q_W-1:0]            n_qy;
    logic signed [bpwf_pkg::VEL_W-1:0]   w_vx;
    logic signed [bpwf_pkg::VEL_W-1:0]   w_vy;

    // Wall line deltas from the saturated points.
    always_comb begin
        w_dx = {r_ent.x2[23], r_ent.x2} - {r_ent.x1[23], r_ent.x1};
        w_dy = {r_ent.y2[23], r_ent.y2} - {r_ent.y1[23], r_ent.y1};
    end

    // Full-width products of the speed and the delta magnitudes.
    assign w_mx = i_speed * r_ax;
    assign w_my = i_speed * r_ay;

    // Square root: two radicand bits and one result bit per step, SQ_STEPS steps per cycle.
    always_comb begin
        n_s     = r_s;
        n_root  = r_root;
        n_rem   = r_rem;
        w_trial = '0;
        for (int i = 0; i < bpwf_pkg::SQ_STEPS; i++) begin
            n_rem   = {n_rem[bpwf_pkg::REM_W-3:0], n_s[bpwf_pkg::SQ_IN_W-1 -: 2]};
            n_s     = {n_s[bpwf_pkg::SQ_IN_W-3:0], 2'b00};
            w_trial = bpwf_pkg::REM_W'({n_root, 2'b01});
            if (n_rem >= w_trial) begin
                n_rem  = n_rem - w_trial;
                n_root = {n_root[bpwf_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_root = {n_root[bpwf_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Restoring divide of both numerators by the same shifting divisor.
    always_comb begin
        n_nx  = r_nx;
        n_ny  = r_ny;
        n_div = r_div;
        n_qx  = r_qx;
        n_qy  = r_qy;
        for (int i = 0; i < bpwf_pkg::DIV_STEPS; i++) begin
            if (n_nx >= n_div) begin
                n_nx = n_nx - n_div;
                n_qx = {n_qx[bpwf_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_qx = {n_qx[bpwf_pkg::Q_W-2:0], 1'b0};
            end
            if (n_ny >= n_div) begin
                n_ny = n_ny - n_div;
                n_qy = {n_qy[bpwf_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_qy = {n_qy[bpwf_pkg::Q_W-2:0], 1'b0};
            end
            n_div = n_div >> 1;
        end
    end

    // Saturate the final quotients into signed velocities.
    always_comb begin
        w_vx = n_qx[bpwf_pkg::Q_W-1] ? 16'sh7FFF : $signed(n_qx);
        if (r_yneg != r_xneg) begin
            w_vy = (n_qy > 16'd32768) ? 16'sh8000 : $signed(-n_qy);
        end else begin
            w_vy = n_qy[bpwf_pkg::Q_W-1] ? 16'sh7FFF : $signed(n_qy);
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // Sequencer with its datapath registers and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_ent   <= i_head;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_xneg  <= w_dx[bpwf_pkg::POS_W];
                    r_yneg  <= w_dy[bpwf_pkg::POS_W];
                    r_ax    <= w_dx[bpwf_pkg::POS_W] ? 24'(-w_dx) : w_dx[23:0];
                    r_ay    <= w_dy[bpwf_pkg::POS_W] ? 24'(-w_dy) : w_dy[23:0];
                    r_zero  <= (w_dx == '0) && (w_dy == '0);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_sqx   <= r_ax * r_ax;
                    r_sqy   <= r_ay * r_ay;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_s     <= bpwf_pkg::SQ_IN_W'({1'b0, r_sqx} + {1'b0, r_sqy});
                    r_nx    <= bpwf_pkg::NUM_W'(w_mx);
                    r_ny    <= bpwf_pkg::NUM_W'(w_my);
                    r_root  <= '0;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_s    <= n_s;
                    r_root <= n_root;
                    r_rem  <= n_rem;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == bpwf_pkg::CNT_W'(bpwf_pkg::SQ_CYC - 1)) begin
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    // Rounding term of the divide and the aligned divisor.
                    r_nx  <= r_nx + bpwf_pkg::NUM_W'(r_root >> 1);
                    r_ny  <= r_ny + bpwf_pkg::NUM_W'(r_root >> 1);
                    r_div <= bpwf_pkg::NUM_W'(r_root) << (bpwf_pkg::Q_W - 1);
                    r_qx  <= '0;
                    r_qy  <= '0;
                    r_cnt <= '0;
                    if (r_zero) begin
                        // Zero-length wall line, or no obstacle at all.
                        o_valid      <= 1'b1;
                        o_pair_index <= r_ent.pair;
                        o_vel_x      <= '0;
                        o_vel_y      <= '0;
                        o_wall_x1    <= r_ent.x1;
                        o_wall_y1    <= r_ent.y1;
                        o_wall_x2    <= r_ent.x2;
                        o_wall_y2    <= r_ent.y2;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_nx  <= n_nx;
                    r_ny  <= n_ny;
                    r_div <= n_div;
                    r_qx  <= n_qx;
                    r_qy  <= n_qy;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == bpwf_pkg::CNT_W'(bpwf_pkg::DIV_CYC - 1)) begin
                        o_valid      <= 1'b1;
                        o_pair_index <= r_ent.pair;
                        o_vel_x      <= w_vx;
                        o_vel_y      <= w_vy;
                        o_wall_x1    <= r_ent.x1;
                        o_wall_y1    <= r_ent.y1;
                        o_wall_x2    <= r_ent.x2;
                        o_wall_y2    <= r_ent.y2;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- verif/tb_beam_pair_wall_follow_velocity.sv -----
// ----------------------------------------------------------------------------
// tb_beam_pair_wall_follow_velocity
// Self-checking testbench for the wall-following velocity block. A directed
// table covers the extremes and the corner cases of the wall line, then random
// scans run under several threshold and speed settings and several rates of
// sender idling. Every result is checked field by field against its table row
// or an in-bench predictor of the wall points and velocity along the wall line.
// ----------------------------------------------------------------------------
module tb_beam_pair_wall_follow_velocity;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [bpwf_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd2;
    localparam int RANDOM_SCANS = 1500;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [0:bpwf_pkg::NUM_BEAMS-1][bpwf_pkg::BEAM_W-1:0] beam;
        logic signed [bpwf_pkg::POS_W-1:0]                    px;
        logic signed [bpwf_pkg::POS_W-1:0]                    py;
    } t_scan;

    typedef struct packed {
        logic [bpwf_pkg::PAIR_W-1:0]       pair;
        logic signed [bpwf_pkg::VEL_W-1:0] vx;
        logic signed [bpwf_pkg::VEL_W-1:0] vy;
        logic signed [bpwf_pkg::POS_W-1:0] x1;
        logic signed [bpwf_pkg::POS_W-1:0] y1;
        logic signed [bpwf_pkg::POS_W-1:0] x2;
        logic signed [bpwf_pkg::POS_W-1:0] y2;
    } t_wall_vel;

    typedef struct packed {
        t_scan     s;
        logic      typed;
        t_wall_vel r;
    } t_row;

    // Q16 direction cosines and sines, +120 down to -120 degrees.
    localparam int COS_Q[bpwf_pkg::NUM_BEAMS] = '{-32768, 0, 32768,
        int'(bpwf_pkg::Q_COS30), 65536, int'(bpwf_pkg::Q_COS30), 32768, 0, -32768};
    localparam int SIN_Q[bpwf_pkg::NUM_BEAMS] = '{int'(bpwf_pkg::Q_COS30), 65536,
        int'(bpwf_pkg::Q_COS30), 32768, 0, -32768, -int'(bpwf_pkg::Q_COS30), -65536,
        -int'(bpwf_pkg::Q_COS30)};

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_start;
    logic                               o_busy;
    logic                               i_cfg_we;
    logic [bpwf_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [bpwf_pkg::CFG_W-1:0]         i_cfg_data;
    logic [bpwf_pkg::BEAM_W-1:0]        i_beam_1, i_beam_2, i_beam_3, i_beam_4, i_beam_5;
    logic [bpwf_pkg::BEAM_W-1:0]        i_beam_6, i_beam_7, i_beam_8, i_beam_9;
    logic signed [bpwf_pkg::POS_W-1:0]  i_pos_x, i_pos_y;
    logic                               o_valid;
    logic [bpwf_pkg::PAIR_W-1:0]        o_pair_index;
    logic signed [bpwf_pkg::VEL_W-1:0]  o_vel_x, o_vel_y;
    logic signed [bpwf_pkg::POS_W-1:0]  o_wall_x1, o_wall_y1, o_wall_x2, o_wall_y2;

    logic [bpwf_pkg::CFG_W-1:0] safe_dist;
    logic [bpwf_pkg::CFG_W-1:0] speed;
    t_wall_vel        pending_q[$];
    t_row             rows[$];
    int               n_err;
    int               idle_pct;

    beam_pair_wall_follow_velocity u_dut (.*);

    // Clock with a period of 8.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint beam_offset(longint d, int c);
        longint mag;
        longint r;
        mag = (c < 0) ? -c : c;
        r = (d * mag + 32768) >>> 16;
        return (c < 0) ? -r : r;
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Expected wall points and velocity for one scan under the current settings.
    function automatic t_wall_vel wall_velocity(t_scan s);
        t_wall_vel r;
        int k;
        int pair;
        longint x1, y1, x2, y2, dx, dy, vx, vy, ax, ay;
        longint unsigned sq, root, bit_q, len;
        r = '0;
        pair = 0;
        for (k = 0; k < bpwf_pkg::NUM_BEAMS - 1; k++) begin
            if (pair == 0 && s.beam[k] < safe_dist && s.beam[k+1] < safe_dist) pair = k + 1;
        end
        if (pair == 0) return r;
        k = pair - 1;
        x1 = clamp_pos(s.px + beam_offset(s.beam[k], COS_Q[k]));
        y1 = clamp_pos(s.py + beam_offset(s.beam[k], SIN_Q[k]));
        x2 = clamp_pos(s.px + beam_offset(s.beam[k+1], COS_Q[k+1]));
        y2 = clamp_pos(s.py + beam_offset(s.beam[k+1], SIN_Q[k+1]));
        dx = x2 - x1;
        dy = y2 - y1;
        vx = 0;
        vy = 0;
        if (dx != 0 || dy != 0) begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            // Integer square root of the squared wall length.
            sq = ax * ax + ay * ay;
            root = 0;
            bit_q = 64'd1 << 62;
            while (bit_q > sq) bit_q >>= 2;
            while (bit_q != 0) begin
                if (sq >= root + bit_q) begin
                    sq -= root + bit_q;
                    root = (root >> 1) + bit_q;
                end else begin
                    root >>= 1;
                end
                bit_q >>= 2;
            end
            len = root;
            vx = (longint'(speed) * ax + longint'(len / 2)) / longint'(len);
            vy = (longint'(speed) * ay + longint'(len / 2)) / longint'(len);
            if ((dx < 0) != (dy < 0)) vy = -vy;
            if (vx > 32767) vx = 32767;
            if (vy > 32767) vy = 32767;
            if (vy < -32768) vy = -32768;
        end
        r.pair = pair[bpwf_pkg::PAIR_W-1:0];
        r.vx = vx[bpwf_pkg::VEL_W-1:0];
        r.vy = vy[bpwf_pkg::VEL_W-1:0];
        r.x1 = x1[bpwf_pkg::POS_W-1:0];
        r.y1 = y1[bpwf_pkg::POS_W-1:0];
        r.x2 = x2[bpwf_pkg::POS_W-1:0];
        r.y2 = y2[bpwf_pkg::POS_W-1:0];
        return r;
    endfunction

    // Present one scan, hold it until the transfer, and record its expectation.
    // Returns at the falling edge after the transfer with i_start still high.
    task automatic send_scan(t_scan s, logic typed, t_wall_vel r);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        {i_beam_1, i_beam_2, i_beam_3, i_beam_4, i_beam_5,
         i_beam_6, i_beam_7, i_beam_8, i_beam_9} <= s.beam;
        i_pos_x <= s.px;
        i_pos_y <= s.py;
        do @(posedge i_clk); while (o_busy);
        pending_q.push_back(typed ? r : wall_velocity(s));
        @(negedge i_clk);
    endtask

    // Drain all results, then write one register while the block is idle.
    task automatic write_reg(logic [bpwf_pkg::CFG_IDX_W-1:0] idx,
                             logic [bpwf_pkg::CFG_W-1:0] val);
        i_start <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bpwf_pkg::CFG_SAFE) safe_dist = val;
        else if (idx == bpwf_pkg::CFG_SPEED) speed = val;
    endtask

    function automatic t_scan random_scan();
        t_scan s;
        int k;
        int p;
        for (k = 0; k < bpwf_pkg::NUM_BEAMS; k++) begin
            s.beam[k] = $urandom_range(3) == 0 ? bpwf_pkg::BEAM_W'($urandom)
                      : bpwf_pkg::BEAM_W'($urandom_range(65535, safe_dist));
        end
        // Most scans carry a wall at a random pair, some have near hits elsewhere.
        if (safe_dist != 0 && $urandom_range(9) != 0) begin
            p = $urandom_range(bpwf_pkg::NUM_BEAMS - 2);
            s.beam[p] = bpwf_pkg::BEAM_W'($urandom_range(safe_dist - 1));
            s.beam[p+1] = $urandom_range(3) == 0 ? bpwf_pkg::BEAM_W'(safe_dist - 1)
                        : bpwf_pkg::BEAM_W'($urandom_range(safe_dist - 1));
            if ($urandom_range(3) == 0) s.beam[p+1] = s.beam[p];
        end
        case ($urandom_range(5))
            0:       s.px = 24'sh7FFFFF - bpwf_pkg::POS_W'($urandom_range(70000));
            1:       s.px = 24'sh800000 + bpwf_pkg::POS_W'($urandom_range(70000));
            default: s.px = bpwf_pkg::POS_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       s.py = 24'sh7FFFFF - bpwf_pkg::POS_W'($urandom_range(70000));
            1:       s.py = 24'sh800000 + bpwf_pkg::POS_W'($urandom_range(70000));
            default: s.py = bpwf_pkg::POS_W'($urandom);
        endcase
        return s;
    endfunction

    // Check every result against the oldest expectation.
    always @(posedge i_clk) begin
        t_wall_vel e;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $error("result with no scan outstanding");
                n_err++;
            end else begin
                e = pending_q.pop_front();
                if (o_pair_index !== e.pair) begin
                    $error("pair_index exp %0d got %0d", e.pair, o_pair_index);
                    n_err++;
                end
                if (o_vel_x !== e.vx) begin
                    $error("vel_x exp %0d got %0d", e.vx, o_vel_x);
                    n_err++;
                end
                if (o_vel_y !== e.vy) begin
                    $error("vel_y exp %0d got %0d", e.vy, o_vel_y);
                    n_err++;
                end
                if (o_wall_x1 !== e.x1) begin
                    $error("wall_x1 exp %0d got %0d", e.x1, o_wall_x1);
                    n_err++;
                end
                if (o_wall_y1 !== e.y1) begin
                    $error("wall_y1 exp %0d got %0d", e.y1, o_wall_y1);
                    n_err++;
                end
                if (o_wall_x2 !== e.x2) begin
                    $error("wall_x2 exp %0d got %0d", e.x2, o_wall_x2);
                    n_err++;
                end
                if (o_wall_y2 !== e.y2) begin
                    $error("wall_y2 exp %0d got %0d", e.y2, o_wall_y2);
                    n_err++;
                end
            end
        end
    end

    // Run limit.
    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row row;
        int i;
        int ph;
        n_err = 0;
        idle_pct = 0;
        safe_dist = bpwf_pkg::SAFE_RESET;
        speed = bpwf_pkg::SPEED_RESET;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bpwf_pkg::CFG_SAFE;
        i_cfg_data = '0;
        {i_beam_1, i_beam_2, i_beam_3, i_beam_4, i_beam_5,
         i_beam_6, i_beam_7, i_beam_8, i_beam_9} = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table at reset settings: threshold 512, speed 768.
        row = '0;
        row.typed = 1'b1;
        row.s.beam = {bpwf_pkg::NUM_BEAMS{16'hFFFF}};
        rows.push_back(row);                       // open space
        row.s.beam = {bpwf_pkg::NUM_BEAMS{16'd512}};
        rows.push_back(row);                       // range equal to threshold
        row.s.beam = '0;
        row.r.pair = 4'd1;
        rows.push_back(row);                       // both points on the vehicle
        row.s.beam = {16'd0, 16'd256, {7{16'hFFFF}}};
        row.r = '{pair: 4'd1, vx: 16'sd0, vy: 16'sd768, x1: 0, y1: 0, x2: 0, y2: 256};
        rows.push_back(row);                       // vertical wall, upward
        row.s.beam = {{6{16'hFFFF}}, 16'd0, 16'd256, 16'hFFFF};
        row.r = '{pair: 4'd7, vx: 16'sd0, vy: -16'sd768, x1: 0, y1: 0, x2: 0, y2: -256};
        rows.push_back(row);                       // vertical wall, downward
        row.typed = 1'b0;
        for (i = 1; i <= bpwf_pkg::NUM_BEAMS - 1; i++) begin
            row.s.beam = {bpwf_pkg::NUM_BEAMS{16'hFFFF}};
            row.s.beam[i-1] = 16'd100 + 16'(i * 37);
            row.s.beam[i] = 16'd511 - 16'(i * 13);
            row.s.px = (i % 2) ? 24'sh7FFFF0 : 24'sh800010;
            row.s.py = (i % 3) ? 24'sh800005 : 24'sh7FFFFA;
            rows.push_back(row);                   // each pair, near the position limits
        end
        row.s.beam = {bpwf_pkg::NUM_BEAMS{16'd511}};
        row.s.px = 24'sh555555;
        row.s.py = 24'shAAAAAA;
        rows.push_back(row);                       // all beams just under threshold
        foreach (rows[i]) send_scan(rows[i].s, rows[i].typed, rows[i].r);

        // Extreme settings, an ignored write, and random settings, with idling.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(bpwf_pkg::CFG_SAFE, 16'd0);
                    write_reg(bpwf_pkg::CFG_SPEED, 16'hFFFF);
                end
                1: begin
                    write_reg(bpwf_pkg::CFG_SAFE, 16'hFFFF);
                    write_reg(CFG_NONE, 16'h0001);
                end
                2: write_reg(bpwf_pkg::CFG_SPEED, 16'd0);
                3: begin
                    write_reg(bpwf_pkg::CFG_SAFE, 16'd2000);
                    write_reg(bpwf_pkg::CFG_SPEED, 16'd768);
                end
                default: begin
                    write_reg(bpwf_pkg::CFG_SAFE, bpwf_pkg::CFG_W'($urandom));
                    write_reg(bpwf_pkg::CFG_SPEED, bpwf_pkg::CFG_W'($urandom));
                end
            endcase
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 60 : 10;
            for (i = 0; i < RANDOM_SCANS / 6; i++) send_scan(random_scan(), 1'b0, '0);
        end
        i_start <= 1'b0;

        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
